// ===== hw/rtl/pip_pkg.sv =====
// types shared by the even-odd point-in-polygon datapath
// no dependencies; imported by pip_edge_mul, pip_parity and the top level
`timescale 1ns / 1ps

package pip_pkg;

    // how one edge acts on the crossing parity
    typedef enum logic [2:0] {
        CLS_SKIP  = 3'b001,
        CLS_CROSS = 3'b010,
        CLS_SLOPE = 3'b100
    } edge_cls_t;

    // per-edge control carried alongside the products
    typedef struct packed {
        edge_cls_t cls;
        logic      dy_neg;
        logic      first;
        logic      last;
    } edge_ctrl_t;

endpackage

// ===== hw/rtl/pip_edge_mul.sv =====
// edge classification and cross products, one registered stage
// depends on pip_pkg for edge_cls_t and edge_ctrl_t
`timescale 1ns / 1ps

module pip_edge_mul #(
    parameter int COORD_BITS = 24
) (
    input  logic                             aclk,
    input  logic                             load,
    input  logic signed [COORD_BITS-1:0]     point_x,
    input  logic signed [COORD_BITS-1:0]     point_y,
    input  logic signed [COORD_BITS-1:0]     org_x,
    input  logic signed [COORD_BITS-1:0]     org_y,
    input  logic signed [COORD_BITS-1:0]     dest_x,
    input  logic signed [COORD_BITS-1:0]     dest_y,
    input  logic                             first_edge,
    input  logic                             last_edge,
    output logic signed [2*COORD_BITS+1:0]   lhs_reg,
    output logic signed [2*COORD_BITS+1:0]   rhs_reg,
    output pip_pkg::edge_ctrl_t              ctrl_reg
);
    import pip_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] dx, dy, rx, ry;
    logic signed [PW-1:0] lhs_next, rhs_next;
    logic                 oy_above, ey_above;
    edge_ctrl_t           ctrl_next;

    // differences widened by one bit so they never wrap
    assign dx = {dest_x[COORD_BITS-1], dest_x} - {org_x[COORD_BITS-1], org_x};
    assign dy = {dest_y[COORD_BITS-1], dest_y} - {org_y[COORD_BITS-1], org_y};
    assign rx = {point_x[COORD_BITS-1], point_x} - {dest_x[COORD_BITS-1], dest_x};
    assign ry = {point_y[COORD_BITS-1], point_y} - {dest_y[COORD_BITS-1], dest_y};

    // (px - ex) * dy against (py - ey) * dx; the sense of this test follows the sign
    // of dy, so pip_parity flips the comparison when dy_neg is set
    assign lhs_next = rx * dy;
    assign rhs_next = ry * dx;

    assign oy_above = org_y > point_y;
    assign ey_above = dest_y > point_y;

    always_comb begin
        ctrl_next.dy_neg = dy[DW-1];
        ctrl_next.first  = first_edge;
        ctrl_next.last   = last_edge;
        if (oy_above == ey_above) begin
            ctrl_next.cls = CLS_SKIP;
        end else if ((org_x > point_x) && (dest_x > point_x)) begin
            ctrl_next.cls = CLS_SKIP;
        end else if ((org_x <= point_x) && (dest_x <= point_x)) begin
            ctrl_next.cls = CLS_CROSS;
        end else begin
            ctrl_next.cls = CLS_SLOPE;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lhs_reg  <= lhs_next;
            rhs_reg  <= rhs_next;
            ctrl_reg <= ctrl_next;
        end
    end

endmodule

// ===== hw/rtl/pip_parity.sv =====
// product compare, crossing parity and result register
// depends on pip_pkg for edge_cls_t and edge_ctrl_t
`timescale 1ns / 1ps

module pip_parity #(
    parameter int COORD_BITS = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             retire,
    input  logic signed [2*COORD_BITS+1:0]   lhs,
    input  logic signed [2*COORD_BITS+1:0]   rhs,
    input  pip_pkg::edge_ctrl_t              ctrl,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic                             m_inside_res
);
    import pip_pkg::*;

    logic parity_reg, parity_next;
    logic valid_reg, valid_next;
    logic res_reg, res_next;
    logic toggle;

    always_comb begin
        case (ctrl.cls)
            CLS_SKIP:  toggle = 1'b0;
            CLS_CROSS: toggle = 1'b1;
            CLS_SLOPE: toggle = ctrl.dy_neg ? (lhs < rhs) : (lhs > rhs);
            default:   toggle = 1'b0;
        endcase
    end

    always_comb begin
        parity_next = parity_reg;
        valid_next  = valid_reg && !m_ready;
        res_next    = res_reg;
        if (retire) begin
            parity_next = (ctrl.first ? 1'b0 : parity_reg) ^ toggle;
            if (ctrl.last) begin
                valid_next = 1'b1;
                res_next   = parity_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            parity_reg <= parity_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid      = valid_reg;
    assign m_inside_res = res_reg;

endmodule

// ===== hw/rtl/point_in_polygon_even_odd_top.sv =====
// top level of the even-odd point-in-polygon tester
// depends on pip_pkg, pip_edge_mul and pip_parity
`timescale 1ns / 1ps

// channel  direction  signals                                   beat
// s_       in         s_valid s_ready, point/org/dest x y, flags one polygon edge
// m_       out        m_valid m_ready, m_inside_res             one inside flag per query
//
// three register levels: input register, product register, result register
// one edge per cycle unless a last edge is held; a retiring last edge sets m_valid
// the two cross products in pip_edge_mul set the cycle time
// reset clears the valid bits and the crossing parity; payload registers are not reset
// a waiting result only stalls edges flagged last; other edges keep flowing unless queued behind one

module point_in_polygon_even_odd_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_point_x,
    input  logic signed [COORD_BITS-1:0]  s_point_y,
    input  logic signed [COORD_BITS-1:0]  s_org_x,
    input  logic signed [COORD_BITS-1:0]  s_org_y,
    input  logic signed [COORD_BITS-1:0]  s_dest_x,
    input  logic signed [COORD_BITS-1:0]  s_dest_y,
    input  logic                          s_first_edge,
    input  logic                          s_last_edge,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_inside_res
);
    import pip_pkg::*;

    // input register
    logic signed [COORD_BITS-1:0] px_reg, py_reg, ox_reg, oy_reg, ex_reg, ey_reg;
    logic                         first_reg, last_reg;
    logic                         v0_reg, v0_next;

    // product stage
    logic signed [2*COORD_BITS+1:0] lhs_reg, rhs_reg;
    edge_ctrl_t                     ctrl_reg;
    logic                           v1_reg, v1_next;

    logic in_take, move0, move1, out_free;

    // an edge leaves the product stage unless it is a last edge and the
    // result slot is still occupied
    assign out_free = !m_valid || m_ready;
    assign move1    = v1_reg && (!ctrl_reg.last || out_free);
    assign move0    = v0_reg && (!v1_reg || move1);
    assign s_ready  = !v0_reg || move0;
    assign in_take  = s_valid && s_ready;

    always_comb begin
        v0_next = v0_reg;
        if (in_take) begin
            v0_next = 1'b1;
        end else if (move0) begin
            v0_next = 1'b0;
        end
        v1_next = v1_reg;
        if (move0) begin
            v1_next = 1'b1;
        end else if (move1) begin
            v1_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    // capture the beat
    always_ff @(posedge aclk) begin
        if (in_take) begin
            px_reg    <= s_point_x;
            py_reg    <= s_point_y;
            ox_reg    <= s_org_x;
            oy_reg    <= s_org_y;
            ex_reg    <= s_dest_x;
            ey_reg    <= s_dest_y;
            first_reg <= s_first_edge;
            last_reg  <= s_last_edge;
        end
    end

    // classification and cross products
    pip_edge_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_mul (
        .aclk       (aclk),
        .load       (move0),
        .point_x    (px_reg),
        .point_y    (py_reg),
        .org_x      (ox_reg),
        .org_y      (oy_reg),
        .dest_x     (ex_reg),
        .dest_y     (ey_reg),
        .first_edge (first_reg),
        .last_edge  (last_reg),
        .lhs_reg    (lhs_reg),
        .rhs_reg    (rhs_reg),
        .ctrl_reg   (ctrl_reg)
    );

    // compare, parity update and result register
    pip_parity #(
        .COORD_BITS (COORD_BITS)
    ) u_parity (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .retire       (move1),
        .lhs          (lhs_reg),
        .rhs          (rhs_reg),
        .ctrl         (ctrl_reg),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_inside_res (m_inside_res)
    );

endmodule
